// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants and round functions for the SHA-256 hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 64;
  localparam int unsigned CountW    = 61;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    unique case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    unique case (t)
      6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

// File: rtl/sha_ram.sv
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// SHA-256 over a byte stream; block buffer held in a 16 x 32 word RAM.
// ----------------------------------------------------------------------------
// data byte: a block-completing byte starts a compression (fetch, 64
//   rounds, hash update) in the single round unit; input stalls meanwhile
// finish: padding and length writes, one or two compressions, then eight
//   digest words, one per cycle while the output is not stalled
// reset: hash at initial value, byte count zero, output empty; buffer RAM
//   is not cleared as every word is written before it is read
`timescale 1ns / 1ps

module sha256_hash_engine_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha_pkg::word_t      digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);

  import sha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_LEN_HI, S_LEN_LO, S_PREP, S_ROUND, S_FINAL, S_EMIT
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  word_t             word_q;
  word_t             hash_q  [HashWords];
  word_t             v_q     [HashWords];
  word_t             sched_q [BlockWords];
  logic [5:0]        rcnt_q;
  logic [4:0]        widx_q;
  logic              spill_q;
  logic              fin_q;
  logic [2:0]        eidx_q;
  logic              out_valid_q;
  word_t             out_word_q;
  logic [2:0]        out_idx_q;

  logic       in_xfer;
  logic [5:0] pos;
  word_t      data_word, pad_word, wt, t1, t2, ch, maj, rdata;
  logic       we, re;
  logic [3:0] waddr, raddr;
  word_t      wdata;
  logic [4:0] pad_lim;
  logic       out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign pos        = count_q[5:0];
  assign pad_lim    = spill_q ? 5'd16 : 5'd14;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // big-endian lanes: byte 0 of a word sits in bits 31:24
  always_comb begin
    data_word = word_q;
    pad_word  = '0;
    for (int l = 0; l < 4; l++) begin
      if (l == int'(pos[1:0])) begin
        data_word[31-8*l -: 8] = data_byte_i;
        pad_word[31-8*l -: 8]  = PAD_BYTE;
      end else if (l < int'(pos[1:0])) begin
        pad_word[31-8*l -: 8]  = word_q[31-8*l -: 8];
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos[5:2];
    wdata = data_word;
    re    = 1'b0;
    raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (kind_i == KIND_FINISH)) begin
          we    = 1'b1;
          wdata = pad_word;
        end else if (in_xfer && (pos[1:0] == 2'd3)) begin
          we    = 1'b1;
        end
      end
      S_PAD: begin
        we    = (widx_q < pad_lim);
        waddr = widx_q[3:0];
        wdata = '0;
      end
      S_LEN_HI: begin
        we    = 1'b1;
        waddr = 4'd14;
        wdata = count_q[CountW-1:29];
      end
      S_LEN_LO: begin
        we    = 1'b1;
        waddr = 4'd15;
        wdata = {count_q[28:0], 3'b000};
      end
      S_PREP: begin
        re    = 1'b1;
      end
      S_ROUND: begin
        re    = 1'b1;
        raddr = rcnt_q[3:0] + 4'd1;
      end
      default: ;
    endcase
  end

  sha_ram #(
    .Width (WordW),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // message schedule: first sixteen words come straight from the buffer
  always_comb begin
    if (rcnt_q < 6'd16) begin
      wt = rdata;
    end else begin
      wt = small_sigma1(sched_q[14]) + sched_q[9] + small_sigma0(sched_q[1]) + sched_q[0];
    end
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rcnt_q) + wt;
    t2  = big_sigma0(v_q[0]) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rcnt_q      <= '0;
      widx_q      <= '0;
      spill_q     <= 1'b0;
      fin_q       <= 1'b0;
      eidx_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HashWords; i++) begin
        hash_q[i] <= init_hash(3'(i));
      end
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && (kind_i == KIND_FINISH)) begin
            fin_q   <= 1'b1;
            spill_q <= (pos[5:3] == 3'b111);
            widx_q  <= {1'b0, pos[5:2]} + 5'd1;
            state_q <= S_PAD;
          end else if (in_xfer) begin
            word_q  <= data_word;
            count_q <= count_q + 1'b1;
            fin_q   <= 1'b0;
            if (pos == 6'd63) begin
              state_q <= S_PREP;
            end
          end
        end
        S_PAD: begin
          if (widx_q < pad_lim) begin
            widx_q <= widx_q + 5'd1;
          end else if (spill_q) begin
            state_q <= S_PREP;
          end else begin
            state_q <= S_LEN_HI;
          end
        end
        S_LEN_HI: state_q <= S_LEN_LO;
        S_LEN_LO: state_q <= S_PREP;
        S_PREP: begin
          rcnt_q  <= '0;
          for (int i = 0; i < HashWords; i++) begin
            v_q[i] <= hash_q[i];
          end
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < BlockWords - 1; i++) begin
            sched_q[i] <= sched_q[i+1];
          end
          sched_q[BlockWords-1] <= wt;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rcnt_q <= rcnt_q + 6'd1;
          if (rcnt_q == 6'(Rounds - 1)) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < HashWords; i++) begin
            hash_q[i] <= hash_q[i] + v_q[i];
          end
          if (spill_q) begin
            spill_q <= 1'b0;
            widx_q  <= '0;
            state_q <= S_PAD;
          end else if (fin_q) begin
            eidx_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_word_q  <= hash_q[eidx_q];
            out_idx_q   <= eidx_q;
            eidx_q      <= eidx_q + 3'd1;
            if (eidx_q == 3'd7) begin
              for (int i = 0; i < HashWords; i++) begin
                hash_q[i] <= init_hash(3'(i));
              end
              count_q <= '0;
              fin_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd7);

endmodule

// File: rtl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks for the SHA-256 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sha_pkg::word_t      digest_word_o,
  input logic [2:0]          word_index_o,
  input logic                last_word_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("stalled digest word changed");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last word flag out of step with index");

  // digest words follow each other without gaps
  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word sequence broken");

  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> in_stall_o)
    else $error("input taken during digest output");

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);
